FILE: design/box_blur_3x3_clipped_edges_macros.svh
// ----------------------------------------------------------------------------
// box blur assertion macros
// shared concurrent assertion shorthands, sampled on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_CLIPPED_EDGES_MACROS_SVH
`define BOX_BLUR_3X3_CLIPPED_EDGES_MACROS_SVH

// condition holds at every sampled edge
`define BB3_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define BB3_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg
// types, constants and the rounding divider shared by the box blur modules
// ----------------------------------------------------------------------------
package bb3_pkg;

    localparam int PIXEL_W            = 8;
    localparam int RGB_W              = 3 * PIXEL_W;
    localparam int LINE_W             = 2 * RGB_W;
    localparam int MAX_WIDTH_DEFAULT  = 1024;
    localparam int FW_W               = 11;
    localparam int HGT_W              = 13;
    localparam int ROW_W              = 12;
    localparam int MIN_SIZE           = 2;
    localparam int HEIGHT_MAX         = 4096;
    localparam int FRAME_WIDTH_RESET  = 640;
    localparam int FRAME_HEIGHT_RESET = 480;
    localparam int CFG_INDEX_W        = 1;
    localparam int CFG_DATA_W         = 13;
    localparam int WIN_DIM            = 3;
    localparam int WIN_SIZE           = WIN_DIM * WIN_DIM;
    localparam int SUM_W              = 12;
    localparam int N_W                = 4;
    localparam int FIFO_DEPTH         = 8;
    localparam int FIFO_PTR_W         = 3;
    localparam int FIFO_CNT_W         = 4;

    // neighbor counts of the clipped window
    localparam logic [N_W-1:0] N_FULL   = 4'd9;
    localparam logic [N_W-1:0] N_EDGE   = 4'd6;
    localparam logic [N_W-1:0] N_CORNER = 4'd4;

    // reciprocals, exact for sums below 2**13
    localparam int              RECIP_SHIFT = 15;
    localparam int              PROD_W      = 26;
    localparam logic [12:0]     RECIP_6     = 13'd5462;
    localparam logic [12:0]     RECIP_9     = 13'd3641;

    typedef enum logic {
        MODE_PIXEL = 1'b0,
        MODE_FLUSH = 1'b1
    } mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] blue;
        logic [PIXEL_W-1:0] green;
        logic [PIXEL_W-1:0] red;
    } pixel_t;

    typedef struct packed {
        logic top_ok;
        logic bot_ok;
        logic left_ok;
        logic right_ok;
        logic last;
    } emit_info_t;

    typedef struct packed {
        logic   last;
        pixel_t pixel;
    } result_t;

    // (sum + n/2) / n for n of 4, 6 or 9
    function automatic logic [PIXEL_W-1:0] div_round(input logic [SUM_W-1:0] sum,
                                                    input logic [N_W-1:0]   n);
        logic [SUM_W:0]    biased;
        logic [PROD_W-1:0] prod;
        logic [PIXEL_W-1:0] q;
        biased = (SUM_W+1)'(sum) + (SUM_W+1)'(n >> 1);
        prod   = '0;
        case (n)
            N_FULL:
            begin
                prod = PROD_W'(biased) * PROD_W'(RECIP_9);
                q    = prod[RECIP_SHIFT +: PIXEL_W];
            end
            N_EDGE:
            begin
                prod = PROD_W'(biased) * PROD_W'(RECIP_6);
                q    = prod[RECIP_SHIFT +: PIXEL_W];
            end
            default:
            begin
                q = biased[2 +: PIXEL_W];
            end
        endcase
        return q;
    endfunction

endpackage

FILE: design/bb3_ram.sv
// ----------------------------------------------------------------------------
// bb3_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
module bb3_ram import bb3_pkg::*; #(
    parameter int WIDTH = LINE_W,
    parameter int DEPTH = MAX_WIDTH_DEFAULT
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: design/bb3_avg.sv
// ----------------------------------------------------------------------------
// bb3_avg
// masked 3x3 channel sums and rounded mean, two register stages
// ----------------------------------------------------------------------------
module bb3_avg import bb3_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  emit_info_t              in_info,
    input  pixel_t [WIN_SIZE-1:0]   window,
    output logic                    out_valid,
    output pixel_t                  out_pixel,
    output logic                    out_last
);

    logic [WIN_DIM-1:0] row_ok;
    logic [WIN_DIM-1:0] col_ok;
    logic [SUM_W-1:0]   sum_red_next;
    logic [SUM_W-1:0]   sum_green_next;
    logic [SUM_W-1:0]   sum_blue_next;
    logic [N_W-1:0]     n_next;

    logic               sum_valid_reg;
    logic [SUM_W-1:0]   sum_red_reg;
    logic [SUM_W-1:0]   sum_green_reg;
    logic [SUM_W-1:0]   sum_blue_reg;
    logic [N_W-1:0]     n_reg;
    logic               sum_last_reg;

    logic               out_valid_reg;
    pixel_t             out_pixel_reg;
    logic               out_last_reg;

    // index 0 is the top row / left column
    always_comb
    begin
        row_ok = {in_info.bot_ok, 1'b1, in_info.top_ok};
        col_ok = {in_info.right_ok, 1'b1, in_info.left_ok};
        sum_red_next   = '0;
        sum_green_next = '0;
        sum_blue_next  = '0;
        for (int r = 0; r < WIN_DIM; r++)
        begin
            for (int c = 0; c < WIN_DIM; c++)
            begin
                if (row_ok[r] && col_ok[c])
                begin
                    sum_red_next   = sum_red_next   + SUM_W'(window[r*WIN_DIM+c].red);
                    sum_green_next = sum_green_next + SUM_W'(window[r*WIN_DIM+c].green);
                    sum_blue_next  = sum_blue_next  + SUM_W'(window[r*WIN_DIM+c].blue);
                end
            end
        end
        if (&row_ok && &col_ok)
        begin
            n_next = N_FULL;
        end
        else if (&row_ok || &col_ok)
        begin
            n_next = N_EDGE;
        end
        else
        begin
            n_next = N_CORNER;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_valid_reg <= in_valid;
            out_valid_reg <= sum_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            sum_red_reg   <= sum_red_next;
            sum_green_reg <= sum_green_next;
            sum_blue_reg  <= sum_blue_next;
            n_reg         <= n_next;
            sum_last_reg  <= in_info.last;
        end
        if (sum_valid_reg)
        begin
            out_pixel_reg.red   <= div_round(sum_red_reg, n_reg);
            out_pixel_reg.green <= div_round(sum_green_reg, n_reg);
            out_pixel_reg.blue  <= div_round(sum_blue_reg, n_reg);
            out_last_reg        <= sum_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign out_last  = out_last_reg;

endmodule

FILE: design/box_blur_3x3_clipped_edges.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_clipped_edges
// 3x3 rgb box blur with the window clipped at the frame borders
// ----------------------------------------------------------------------------
// pixels enter on s_axis in raster order (tuser low); tuser high is a flush
// tick that drains one pending result once the whole frame has been sent.
// results leave on m_axis in raster order, tlast on the final pixel of the
// frame. each result is released one row plus one pixel after its own input
// pixel, and m_axis_tvalid rises once that result is in the output fifo.
// throughput is one item per clock while s_axis_tready is high: the line
// ram (both rows above, one word per column) does one read and one write
// per cycle, bypassing a read of the column written in the same cycle.
// frame size is set on the cfg channel (index 0 width, 1 height); any write
// restarts the frame. cfg_ready is always high.
// when m_axis stalls, results queue in an 8-entry output fifo and
// s_axis_tready drops once 8 results are owed but not yet transferred.
// reset clears all counters and sets 640x480; the line ram is not cleared,
// entries never written are only read for masked neighbors.
// ----------------------------------------------------------------------------
`include "box_blur_3x3_clipped_edges_macros.svh"

module box_blur_3x3_clipped_edges import bb3_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [RGB_W-1:0]       s_axis_tdata,   // red_in, green_in, blue_in
    input  logic                   s_axis_tuser,   // mode
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [RGB_W-1:0]       m_axis_tdata,   // red_out, green_out, blue_out
    output logic                   m_axis_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WID_W  = $clog2(MAX_WIDTH + 1);
    localparam int LEAD_W = $clog2(MAX_WIDTH + 2);
    localparam int RESET_WIDTH =
        (FRAME_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RESET;

    // frame geometry
    logic [WID_W-1:0]  width_reg,  width_next;
    logic [HGT_W-1:0]  height_reg, height_next;
    logic [FW_W-1:0]   cfg_fw;
    logic [HGT_W-1:0]  cfg_fh;
    logic              cfg_fire;

    // position tracking
    logic [COL_W-1:0]  in_col_reg,  in_col_next;
    logic [ROW_W-1:0]  in_row_reg,  in_row_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;
    logic [LEAD_W-1:0] lead_reg,    lead_next;
    logic              draining_reg, draining_next;

    logic [WID_W-1:0]  width_m1;
    logic [LEAD_W-1:0] width_p1;
    logic [LEAD_W-1:0] lead_eff;
    logic              in_fire;
    logic              is_pixel;
    logic              in_col_last;
    logic              in_row_last;
    logic              out_col_last;
    logic              out_row_last;
    logic              flush_active;
    logic              emit;
    logic              rd_en;
    logic [COL_W-1:0]  rd_addr;
    emit_info_t        info_now;

    // stage 1: line ram data returns
    logic              p1_valid_reg;
    logic              p1_pixel_reg;
    logic              p1_emit_reg;
    emit_info_t        p1_info_reg;
    pixel_t            p1_px_reg;
    logic [COL_W-1:0]  p1_addr_reg;
    logic              fwd_reg, fwd_next;
    logic [LINE_W-1:0] last_wr_reg;
    logic [LINE_W-1:0] ram_rd_data;
    logic [LINE_W-1:0] line_rd;
    pixel_t            upper_rd;
    pixel_t            lower_rd;
    pixel_t            new_px;
    logic              wr_en;
    logic [LINE_W-1:0] wr_data;

    // window and averaging
    pixel_t [WIN_SIZE-1:0] window_reg, window_next;
    logic              p2_valid_reg;
    emit_info_t        p2_info_reg;
    logic              avg_valid;
    pixel_t            avg_pixel;
    logic              avg_last;

    // output fifo
    result_t                 fifo_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   fifo_count_reg;
    logic [FIFO_CNT_W-1:0]   reserve_reg;
    logic                    out_fire;

    // ------------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid & cfg_ready;
    assign cfg_fw    = cfg_data[FW_W-1:0];
    assign cfg_fh    = cfg_data[HGT_W-1:0];

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_fire)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_FRAME_WIDTH:
                begin
                    if (cfg_fw < FW_W'(MIN_SIZE))
                    begin
                        width_next = WID_W'(MIN_SIZE);
                    end
                    else if (32'(cfg_fw) > 32'(MAX_WIDTH))
                    begin
                        width_next = WID_W'(MAX_WIDTH);
                    end
                    else
                    begin
                        width_next = WID_W'(cfg_fw);
                    end
                end
                CFG_FRAME_HEIGHT:
                begin
                    if (cfg_fh < HGT_W'(MIN_SIZE))
                    begin
                        height_next = HGT_W'(MIN_SIZE);
                    end
                    else if (cfg_fh > HGT_W'(HEIGHT_MAX))
                    begin
                        height_next = HGT_W'(HEIGHT_MAX);
                    end
                    else
                    begin
                        height_next = cfg_fh;
                    end
                end
                default:
                begin
                    width_next = width_reg;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // stage 0: position bookkeeping and line ram read
    // ------------------------------------------------------------------------
    assign s_axis_tready = (reserve_reg < FIFO_CNT_W'(FIFO_DEPTH));
    assign in_fire       = s_axis_tvalid & s_axis_tready;
    assign is_pixel      = (mode_t'(s_axis_tuser) == MODE_PIXEL);

    assign width_m1     = width_reg - WID_W'(1);
    assign width_p1     = LEAD_W'(width_reg) + LEAD_W'(1);
    assign lead_eff     = draining_reg ? '0 : lead_reg;
    assign in_col_last  = (WID_W'(in_col_reg) == width_m1);
    assign in_row_last  = (HGT_W'(in_row_reg) + HGT_W'(1) == height_reg);
    assign out_col_last = (WID_W'(out_col_reg) == width_m1);
    assign out_row_last = (HGT_W'(out_row_reg) + HGT_W'(1) == height_reg);
    // a flush only drains once the whole frame has been taken in
    assign flush_active = (lead_reg != '0) && (in_row_reg == '0) && (in_col_reg == '0);

    always_comb
    begin
        info_now.top_ok   = (out_row_reg != '0);
        info_now.bot_ok   = !out_row_last;
        info_now.left_ok  = (out_col_reg != '0);
        info_now.right_ok = !out_col_last;
        info_now.last     = out_row_last & out_col_last;
    end

    always_comb
    begin
        in_col_next   = in_col_reg;
        in_row_next   = in_row_reg;
        out_col_next  = out_col_reg;
        out_row_next  = out_row_reg;
        lead_next     = lead_reg;
        draining_next = draining_reg;
        emit          = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = in_col_reg;

        if (in_fire)
        begin
            if (is_pixel)
            begin
                rd_en         = 1'b1;
                draining_next = 1'b0;
                in_col_next   = in_col_last ? '0 : in_col_reg + COL_W'(1);
                if (in_col_last)
                begin
                    in_row_next = in_row_last ? '0 : in_row_reg + ROW_W'(1);
                end
                if (lead_eff >= width_p1)
                begin
                    emit      = 1'b1;
                    lead_next = lead_eff;
                end
                else
                begin
                    lead_next = lead_eff + LEAD_W'(1);
                end
            end
            else if (flush_active)
            begin
                rd_en         = 1'b1;
                rd_addr       = out_col_last ? '0 : out_col_reg + COL_W'(1);
                emit          = 1'b1;
                lead_next     = lead_reg - LEAD_W'(1);
                draining_next = (lead_reg != LEAD_W'(1));
            end
        end

        if (emit)
        begin
            out_col_next = out_col_last ? '0 : out_col_reg + COL_W'(1);
            if (out_col_last)
            begin
                out_row_next = out_row_last ? '0 : out_row_reg + ROW_W'(1);
            end
        end

        // any register write restarts the frame
        if (cfg_fire)
        begin
            in_col_next   = '0;
            in_row_next   = '0;
            out_col_next  = '0;
            out_row_next  = '0;
            lead_next     = '0;
            draining_next = 1'b0;
        end
    end

    // read hits the column the stage-1 item writes this cycle
    assign fwd_next = rd_en && p1_valid_reg && p1_pixel_reg && (rd_addr == p1_addr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WID_W'(RESET_WIDTH);
            height_reg   <= HGT_W'(FRAME_HEIGHT_RESET);
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            lead_reg     <= '0;
            draining_reg <= 1'b0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else
        begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            lead_reg     <= lead_next;
            draining_reg <= draining_next;
            p1_valid_reg <= rd_en;
            p2_valid_reg <= p1_valid_reg & p1_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            p1_pixel_reg <= is_pixel;
            p1_emit_reg  <= emit;
            p1_info_reg  <= info_now;
            p1_px_reg    <= pixel_t'(s_axis_tdata);
            p1_addr_reg  <= rd_addr;
            fwd_reg      <= fwd_next;
        end
    end

    bb3_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (p1_addr_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_rd_data)
    );

    // ------------------------------------------------------------------------
    // stage 1: window shift and line ram write-back
    // ------------------------------------------------------------------------
    assign line_rd  = fwd_reg ? last_wr_reg : ram_rd_data;
    assign upper_rd = pixel_t'(line_rd[LINE_W-1:RGB_W]);
    assign lower_rd = pixel_t'(line_rd[RGB_W-1:0]);
    assign new_px   = p1_pixel_reg ? p1_px_reg : '0;
    assign wr_en    = p1_valid_reg & p1_pixel_reg;
    // rows move up one: the old lower row becomes the upper one
    assign wr_data  = {lower_rd, p1_px_reg};

    always_comb
    begin
        window_next = window_reg;
        for (int r = 0; r < WIN_DIM; r++)
        begin
            window_next[r*WIN_DIM]     = window_reg[r*WIN_DIM+1];
            window_next[r*WIN_DIM + 1] = window_reg[r*WIN_DIM+2];
        end
        window_next[2]              = upper_rd;
        window_next[WIN_DIM + 2]    = lower_rd;
        window_next[2*WIN_DIM + 2]  = new_px;
    end

    always_ff @(posedge clk)
    begin
        if (p1_valid_reg)
        begin
            window_reg  <= window_next;
            p2_info_reg <= p1_info_reg;
        end
        if (wr_en)
        begin
            last_wr_reg <= wr_data;
        end
    end

    bb3_avg u_avg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p2_valid_reg),
        .in_info   (p2_info_reg),
        .window    (window_reg),
        .out_valid (avg_valid),
        .out_pixel (avg_pixel),
        .out_last  (avg_last)
    );

    // ------------------------------------------------------------------------
    // output fifo; space is reserved when a result is decided in stage 0
    // ------------------------------------------------------------------------
    assign out_fire      = m_axis_tvalid & m_axis_tready;
    assign m_axis_tvalid = (fifo_count_reg != '0);
    assign m_axis_tdata  = fifo_mem[rd_ptr_reg].pixel;
    assign m_axis_tlast  = fifo_mem[rd_ptr_reg].last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
            reserve_reg    <= '0;
        end
        else
        begin
            if (avg_valid)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (out_fire)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            fifo_count_reg <= fifo_count_reg + FIFO_CNT_W'(avg_valid)
                                             - FIFO_CNT_W'(out_fire);
            reserve_reg    <= reserve_reg + FIFO_CNT_W'(emit) - FIFO_CNT_W'(out_fire);
        end
    end

    always_ff @(posedge clk)
    begin
        if (avg_valid)
        begin
            fifo_mem[wr_ptr_reg] <= '{last: avg_last, pixel: avg_pixel};
        end
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    `BB3_ASSERT(a_fifo_within_reserve, fifo_count_reg <= reserve_reg,
        "output fifo holds more results than were reserved")
    `BB3_ASSERT(a_no_fifo_overflow, !avg_valid || (fifo_count_reg < FIFO_CNT_W'(FIFO_DEPTH)),
        "result arrived at a full output fifo")
    `BB3_ASSERT(a_lead_bounded, lead_reg <= width_p1,
        "pending result count exceeds one row plus one")
    `BB3_ASSERT_NEXT(a_fifo_drains,
        out_fire && (fifo_count_reg == FIFO_CNT_W'(1)) && !avg_valid,
        !m_axis_tvalid,
        "output valid held after the last queued result was transferred")

endmodule

FILE: tb/box_blur_3x3_clipped_edges_test.sv
// ----------------------------------------------------------------------------
// box_blur_3x3_clipped_edges_test
// self-checking bench for the clipped 3x3 rgb box blur: a scoreboard class
// predicts every blurred pixel and tlast from the accepted stream and the
// frame size registers, and compares them with the m_axis transfers. runs a
// short directed sequence on a 2x2 frame, then random frames over several
// sizes (clamped, masked and extreme) with random drains, continuous frames,
// aborted drains and stray flush ticks, early random stalls on both sides
// ----------------------------------------------------------------------------
module box_blur_3x3_clipped_edges_test import bb3_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned SETTLE_CYCLES = 16;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [RGB_W-1:0]      s_axis_tdata = '0;    // red_in, green_in, blue_in
    mode_t                 s_axis_tuser = MODE_PIXEL;  // mode
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [RGB_W-1:0]      m_axis_tdata;         // red_out, green_out, blue_out
    logic                  m_axis_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    cfg_index_t            cfg_index = CFG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int unsigned send_idle_pct = 8;
    int unsigned recv_idle_pct = 67;
    int unsigned items_sent = 0;
    int unsigned cycle_count = 0;

    function automatic int unsigned size_clamp(int unsigned v, int unsigned hi);
        if (v < MIN_SIZE)
            return MIN_SIZE;
        if (v > hi)
            return hi;
        return v;
    endfunction

    class blur_scoreboard;
        int unsigned width_reg;
        int unsigned height_reg;
        pixel_t      upper_row [MAX_WIDTH_DEFAULT];
        pixel_t      lower_row [MAX_WIDTH_DEFAULT];
        pixel_t      window [WIN_SIZE];
        int unsigned in_col;
        int unsigned in_row;
        int unsigned out_col;
        int unsigned out_row;
        int unsigned held;
        bit          draining;
        result_t     blurred_q [$];
        int unsigned errors;

        function new();
            width_reg = FRAME_WIDTH_RESET;
            height_reg = FRAME_HEIGHT_RESET;
            foreach (upper_row[i])
            begin
                upper_row[i] = '0;
                lower_row[i] = '0;
            end
            foreach (window[i])
                window[i] = '0;
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
            held = 0;
            draining = 1'b0;
            errors = 0;
        endfunction

        function int unsigned pending();
            return blurred_q.size();
        endfunction

        // any write restarts the frame and loses what is still held
        function void write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] val);
            if (idx == CFG_FRAME_WIDTH)
                width_reg = val[FW_W-1:0];
            else
                height_reg = val;
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
            held = 0;
            draining = 1'b0;
        endfunction

        function void shift_window(pixel_t top, pixel_t mid, pixel_t bot);
            pixel_t col [WIN_DIM];
            col[0] = top;
            col[1] = mid;
            col[2] = bot;
            for (int r = 0; r < WIN_DIM; r++)
            begin
                window[r*3]     = window[r*3 + 1];
                window[r*3 + 1] = window[r*3 + 2];
                window[r*3 + 2] = col[r];
            end
        endfunction

        function void blur_center(int unsigned w, int unsigned h);
            int unsigned r0;
            int unsigned r1;
            int unsigned c0;
            int unsigned c1;
            int unsigned n;
            int unsigned sum_r;
            int unsigned sum_g;
            int unsigned sum_b;
            result_t     res;
            r0 = (out_row > 0) ? 0 : 1;
            r1 = (out_row + 1 < h) ? 2 : 1;
            c0 = (out_col > 0) ? 0 : 1;
            c1 = (out_col + 1 < w) ? 2 : 1;
            n = (r1 - r0 + 1) * (c1 - c0 + 1);
            sum_r = 0;
            sum_g = 0;
            sum_b = 0;
            for (int unsigned r = r0; r <= r1; r++)
                for (int unsigned c = c0; c <= c1; c++)
                begin
                    sum_r += window[r*3 + c].red;
                    sum_g += window[r*3 + c].green;
                    sum_b += window[r*3 + c].blue;
                end
            // round half up
            res.pixel.red   = 8'((sum_r + n / 2) / n);
            res.pixel.green = 8'((sum_g + n / 2) / n);
            res.pixel.blue  = 8'((sum_b + n / 2) / n);
            res.last = (out_row + 1 == h) && (out_col + 1 == w);
            blurred_q.push_back(res);
            out_col++;
            if (out_col >= w)
            begin
                out_col = 0;
                out_row++;
                if (out_row >= h)
                    out_row = 0;
            end
        endfunction

        function void note_input(mode_t mode, pixel_t px);
            int unsigned w;
            int unsigned h;
            int unsigned c;
            w = size_clamp(width_reg, MAX_WIDTH_DEFAULT);
            h = size_clamp(height_reg, HEIGHT_MAX);
            if (mode == MODE_PIXEL)
            begin
                // a pixel during a drain drops the rest and starts over
                if (draining)
                begin
                    held = 0;
                    draining = 1'b0;
                end
                c = (in_col >= w) ? 0 : in_col;
                shift_window(upper_row[c], lower_row[c], px);
                upper_row[c] = lower_row[c];
                lower_row[c] = px;
                in_col = c + 1;
                if (in_col >= w)
                begin
                    in_col = 0;
                    in_row++;
                    if (in_row >= h)
                        in_row = 0;
                end
                if (held >= w + 1)
                    blur_center(w, h);
                else
                    held++;
            end
            else if (held != 0 && in_row == 0 && in_col == 0)
            begin
                c = (out_col + 1 >= w) ? 0 : out_col + 1;
                shift_window(upper_row[c], lower_row[c], '0);
                blur_center(w, h);
                held--;
                draining = (held != 0);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (blurred_q.size() == 0)
            begin
                $error("unexpected result: red_out %0d green_out %0d blue_out %0d frame_last %0d",
                       got.pixel.red, got.pixel.green, got.pixel.blue, got.last);
                errors++;
                return;
            end
            want = blurred_q.pop_front();
            if (got.pixel.red !== want.pixel.red)
            begin
                $error("red_out: expected %0d, actual %0d", want.pixel.red, got.pixel.red);
                errors++;
            end
            if (got.pixel.green !== want.pixel.green)
            begin
                $error("green_out: expected %0d, actual %0d", want.pixel.green, got.pixel.green);
                errors++;
            end
            if (got.pixel.blue !== want.pixel.blue)
            begin
                $error("blue_out: expected %0d, actual %0d", want.pixel.blue, got.pixel.blue);
                errors++;
            end
            if (got.last !== want.last)
            begin
                $error("frame_last: expected %0d, actual %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    blur_scoreboard sb = new();

    box_blur_3x3_clipped_edges uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // every transfer is seen with pre-edge values
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready)
                sb.note_input(s_axis_tuser, pixel_t'(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result({m_axis_tlast, m_axis_tdata});
        end
    end

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("box_blur_3x3_clipped_edges_test: FAIL");
        $finish;
    end

    function automatic logic [PIXEL_W-1:0] random_channel();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return PIXEL_W'($urandom_range(255));
        endcase
    endfunction

    function automatic pixel_t random_pixel();
        return {random_channel(), random_channel(), random_channel()};
    endfunction

    task automatic send_item(mode_t mode, pixel_t px);
        if (items_sent < 550)
        begin
            send_idle_pct = 8;
            recv_idle_pct = 67;
        end
        else if (items_sent < 1100)
        begin
            send_idle_pct = 67;
            recv_idle_pct = 8;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= px;
        s_axis_tuser <= mode;
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
    endtask

    // idle until every predicted pixel has come out and the pipe has settled
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_frame(logic [CFG_DATA_W-1:0] w_val, logic [CFG_DATA_W-1:0] h_val);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_FRAME_WIDTH;
        cfg_data <= w_val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_index <= CFG_FRAME_HEIGHT;
        cfg_data <= h_val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // random frames at one size; frames larger than the budget are cut short
    task automatic run_phase(logic [CFG_DATA_W-1:0] w_val, logic [CFG_DATA_W-1:0] h_val,
                             int unsigned budget);
        int unsigned w;
        int unsigned h;
        int unsigned frame_px;
        int unsigned count;
        int unsigned n_flush;
        int unsigned pick;
        bit          partial;
        wait_idle();
        set_frame(w_val, h_val);
        w = size_clamp(w_val[FW_W-1:0], MAX_WIDTH_DEFAULT);
        h = size_clamp(h_val, HEIGHT_MAX);
        frame_px = w * h;
        partial = (frame_px > budget);
        if (partial)
            frame_px = budget;
        count = 0;
        while (count < budget)
        begin
            for (int unsigned p = 0; p < frame_px; p++)
            begin
                // stray flush ticks, mostly in mid frame
                if ($urandom_range(99) < 3)
                    send_item(MODE_FLUSH, random_pixel());
                send_item(MODE_PIXEL, random_pixel());
                count++;
            end
            if (!partial)
            begin
                pick = $urandom_range(99);
                if (pick < 40)
                    n_flush = w + 1 + $urandom_range(2);
                else if (pick < 65)
                    n_flush = $urandom_range(w, 1);
                else
                    n_flush = 0;
                repeat (n_flush) send_item(MODE_FLUSH, random_pixel());
            end
        end
        if (!partial)
            repeat (w + 1) send_item(MODE_FLUSH, random_pixel());
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 2x2 frame from clamped sizes: every pixel is a corner
        set_frame(13'd0, 13'd1);
        send_item(MODE_FLUSH, '1);
        send_item(MODE_PIXEL, '1);
        send_item(MODE_PIXEL, '0);
        send_item(MODE_FLUSH, '1);
        send_item(MODE_PIXEL, {8'd0, 8'd128, 8'd255});
        send_item(MODE_PIXEL, {8'd255, 8'd127, 8'd1});
        repeat (4) send_item(MODE_FLUSH, random_pixel());
        // second frame, drain cut short by a pixel of the next frame
        repeat (4) send_item(MODE_PIXEL, random_pixel());
        send_item(MODE_FLUSH, '0);
        repeat (4) send_item(MODE_PIXEL, random_pixel());
        // back-to-back frame pushes out the previous one
        repeat (4) send_item(MODE_PIXEL, random_pixel());
        repeat (3) send_item(MODE_FLUSH, random_pixel());

        run_phase(13'd3, 13'd2, 48);
        run_phase(13'h0805, 13'd3, 45);
        run_phase(13'd2, 13'd8191, 40);
        run_phase(13'd7, 13'd4, 56);
        run_phase(13'd2047, 13'd0, 1030);
        run_phase(13'd1, 13'd5, 40);
        run_phase(13'd16, 13'd9, 40);
        run_phase(13'd4, 13'd4097, 30);
        run_phase(13'd9, 13'd6, 54);

        wait_idle();
        if (sb.errors == 0)
            $display("box_blur_3x3_clipped_edges_test: PASS");
        else
            $display("box_blur_3x3_clipped_edges_test: FAIL");
        $finish;
    end

endmodule
